/* rtl/wodr_pkg.sv */
// Shared types and constants for the wheel odometry dead-reckoning block.
// Used by wodr_cordic and wheel_odometry_dead_reckoning; depends on nothing.
package wodr_pkg;

    localparam int STEP_W         = 32;
    localparam int HEAD_W         = 16;
    localparam int POS_W          = 48;
    localparam int PROD_W         = 63;
    localparam int Z_W            = 33;
    localparam int ANGLE_IDX_W    = 5;
    localparam int ATAN_TABLE_SIZE = 24;

    localparam logic signed [30:0] GAIN_INV_Q30 = 31'sd652032874;
    localparam logic [7:0]         MAX_TRACKERS = 8'd255;

    localparam logic [29:0] ATAN_TABLE [ATAN_TABLE_SIZE] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
    };

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_TRACK   = 2'd1,
        REQ_UNTRACK = 2'd2,
        REQ_SET_POS = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_MUL,
        S_ROT,
        S_WAIT,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [HEAD_W-1:0] heading;
    } t_cordic_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

endpackage

/* rtl/wheel_odometry_dead_reckoning.sv */
// Dead-reckoning position tracker: top level with request decode, averaging and saturation.
// Depends on wodr_pkg and instantiates wodr_cordic.
//
// One request word is taken at a time. Track, untrack, set-position and ignored samples
// give their result word in the cycle after acceptance, and a sample that only stores its
// average or does not move passes through S_CMP and then S_OUT. A motion sample that
// moves the tracker passes through S_CMP, S_MUL (one multiply), S_ROT (start of the
// single shared CORDIC stage, which performs one rotation step per cycle), S_WAIT and
// S_ADD (one saturating add) before S_OUT. The block is ready again in the cycle after
// its result word is taken. Positions are signed 48-bit with FRACTION_BITS fraction
// bits.
module wheel_odometry_dead_reckoning #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int FRACTION_BITS     = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_req_type,
    input  logic signed [wodr_pkg::STEP_W-1:0]   i_left_steps,
    input  logic signed [wodr_pkg::STEP_W-1:0]   i_right_steps,
    input  logic [wodr_pkg::HEAD_W-1:0]          i_heading_angle,
    input  logic                                 i_sensors_ready,
    input  logic signed [wodr_pkg::POS_W-1:0]    i_new_x,
    input  logic signed [wodr_pkg::POS_W-1:0]    i_new_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [wodr_pkg::POS_W-1:0]    o_pos_x_out,
    output logic signed [wodr_pkg::POS_W-1:0]    o_pos_y_out,
    output logic                                 o_tracking_active,
    output logic [7:0]                           o_tracker_count
);

    localparam int ITERS = (CORDIC_ITERATIONS > wodr_pkg::ATAN_TABLE_SIZE) ?
                           wodr_pkg::ATAN_TABLE_SIZE : CORDIC_ITERATIONS;
    localparam int CW    = FRACTION_BITS + 34;
    localparam int SW    = ((CW > wodr_pkg::POS_W) ? CW : wodr_pkg::POS_W) + 1;
    localparam int PW    = wodr_pkg::POS_W;

    wodr_pkg::t_state r_state, n_state;
    logic             r_mode, n_mode;
    logic [7:0]       r_total, n_total;
    logic [31:0]      r_last, n_last;
    logic             r_stale, n_stale;
    logic signed [PW-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;

    logic [31:0]                         r_avg;
    logic signed [31:0]                  r_delta;
    logic signed [wodr_pkg::PROD_W-1:0]  r_prod;
    logic [wodr_pkg::HEAD_W-1:0]         r_heading;

    wodr_pkg::t_cordic_ctl cordic_ctl;
    wodr_pkg::t_cordic_sts cordic_sts;
    logic signed [CW-1:0]  cordic_x, cordic_y;

    logic        accept;
    logic [32:0] step_sum, step_adj;
    logic [31:0] avg_now;
    logic signed [SW-1:0] sum_x, sum_y;

    function automatic logic signed [wodr_pkg::POS_W-1:0] sat_pos(
        input logic signed [SW-1:0] s
    );
        logic top_ones, top_zeros;
        top_ones  = &s[SW-1:wodr_pkg::POS_W-1];
        top_zeros = ~|s[SW-1:wodr_pkg::POS_W-1];
        if (top_ones || top_zeros) begin
            sat_pos = s[wodr_pkg::POS_W-1:0];
        end else begin
            sat_pos = {s[SW-1], {(wodr_pkg::POS_W-1){~s[SW-1]}}};
        end
    endfunction

    assign accept   = i_in_valid && o_in_ready;
    assign step_sum = {i_left_steps[31], i_left_steps} + {i_right_steps[31], i_right_steps};
    assign step_adj = step_sum + 33'(step_sum[32]);
    assign avg_now  = step_adj[32:1];
    assign sum_x    = SW'(r_pos_x) + SW'(cordic_x);
    assign sum_y    = SW'(r_pos_y) + SW'(cordic_y);

    always_comb begin
        n_state            = r_state;
        n_mode             = r_mode;
        n_total            = r_total;
        n_last             = r_last;
        n_stale            = r_stale;
        n_pos_x            = r_pos_x;
        n_pos_y            = r_pos_y;
        o_in_ready         = 1'b0;
        o_out_valid        = 1'b0;
        cordic_ctl.start   = 1'b0;
        cordic_ctl.heading = r_heading;
        unique case (r_state)
            wodr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = wodr_pkg::S_OUT;
                    unique case (wodr_pkg::t_req'(i_req_type))
                        wodr_pkg::REQ_SAMPLE: begin
                            if (r_mode && i_sensors_ready) begin
                                n_state = wodr_pkg::S_CMP;
                            end
                        end
                        wodr_pkg::REQ_TRACK: begin
                            if (r_total != wodr_pkg::MAX_TRACKERS) begin
                                if (r_total == 8'd0 && !r_mode) begin
                                    n_mode  = 1'b1;
                                    n_stale = 1'b1;
                                end
                                n_total = r_total + 8'd1;
                            end
                        end
                        wodr_pkg::REQ_UNTRACK: begin
                            if (r_total != 8'd0) begin
                                n_total = r_total - 8'd1;
                                if (r_total == 8'd1) begin
                                    n_mode = 1'b0;
                                end
                            end
                        end
                        wodr_pkg::REQ_SET_POS: begin
                            n_pos_x = i_new_x;
                            n_pos_y = i_new_y;
                        end
                        default: ;
                    endcase
                end
            end
            wodr_pkg::S_CMP: begin
                n_last = r_avg;
                if (r_stale) begin
                    n_stale = 1'b0;
                    n_state = wodr_pkg::S_OUT;
                end else if (r_avg == r_last) begin
                    n_state = wodr_pkg::S_OUT;
                end else begin
                    n_state = wodr_pkg::S_MUL;
                end
            end
            wodr_pkg::S_MUL: begin
                n_state = wodr_pkg::S_ROT;
            end
            wodr_pkg::S_ROT: begin
                cordic_ctl.start = 1'b1;
                n_state          = wodr_pkg::S_WAIT;
            end
            wodr_pkg::S_WAIT: begin
                if (cordic_sts.done) begin
                    n_state = wodr_pkg::S_ADD;
                end
            end
            wodr_pkg::S_ADD: begin
                n_pos_x = sat_pos(sum_x);
                n_pos_y = sat_pos(sum_y);
                n_state = wodr_pkg::S_OUT;
            end
            wodr_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = wodr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wodr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wodr_pkg::S_IDLE;
            r_mode  <= 1'b0;
            r_total <= 8'd0;
            r_last  <= 32'd0;
            r_stale <= 1'b1;
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_total <= n_total;
            r_last  <= n_last;
            r_stale <= n_stale;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_avg     <= avg_now;
            r_heading <= i_heading_angle;
        end
        if (r_state == wodr_pkg::S_CMP) begin
            r_delta <= $signed(r_avg - r_last);
        end
        if (r_state == wodr_pkg::S_MUL) begin
            r_prod <= r_delta * wodr_pkg::GAIN_INV_Q30;
        end
    end

    wodr_cordic #(
        .ITERS         (ITERS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cordic_ctl),
        .i_prod  (r_prod),
        .o_sts   (cordic_sts),
        .o_x     (cordic_x),
        .o_y     (cordic_y)
    );

    assign o_pos_x_out       = r_pos_x;
    assign o_pos_y_out       = r_pos_y;
    assign o_tracking_active = r_mode;
    assign o_tracker_count   = r_total;

    a_mode_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == (r_total != 8'd0))
        else $error("Tracking mode disagrees with the tracker count.");

    a_ready_excludes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("Input ready while a result word is pending.");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_sts.done |-> r_state == wodr_pkg::S_WAIT)
        else $error("Rotation finished outside the wait state.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(r_pos_x) && $stable(r_pos_y) && $stable(r_total)))
        else $error("Result word changed while stalled.");

endmodule

/* rtl/wodr_cordic.sv */
// Iterative CORDIC rotation of (x0, 0) by a binary-angle heading, one step per cycle.
// Depends on wodr_pkg for the angle table, widths and control structs.
module wodr_cordic #(
    parameter int ITERS         = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wodr_pkg::t_cordic_ctl                 i_ctl,
    input  logic signed [wodr_pkg::PROD_W-1:0]    i_prod,
    output wodr_pkg::t_cordic_sts                 o_sts,
    output logic signed [FRACTION_BITS+33:0]      o_x,
    output logic signed [FRACTION_BITS+33:0]      o_y
);

    localparam int CW    = FRACTION_BITS + 34;
    localparam int SHIFT = 30 - FRACTION_BITS;
    localparam int IW    = $clog2(ITERS);

    logic signed [CW-1:0]           r_x, r_y, n_x, n_y;
    logic signed [wodr_pkg::Z_W-1:0] r_z, n_z;
    logic [IW-1:0]                  r_iter;
    logic                           r_busy, r_done;

    logic signed [CW-1:0]           x_init, x_sh, y_sh;
    logic                           fold;
    logic [31:0]                    z_word;
    logic signed [wodr_pkg::Z_W-1:0] atan_val;

    always_comb begin
        x_init = CW'(i_prod >>> SHIFT);
        fold   = ^i_ctl.heading[wodr_pkg::HEAD_W-1 -: 2];
        z_word = {i_ctl.heading[wodr_pkg::HEAD_W-1] ^ fold,
                  i_ctl.heading[wodr_pkg::HEAD_W-2:0], 16'b0};
        x_sh     = r_x >>> r_iter;
        y_sh     = r_y >>> r_iter;
        atan_val = $signed({3'b0, wodr_pkg::ATAN_TABLE[wodr_pkg::ANGLE_IDX_W'(r_iter)]});
        if (!r_z[wodr_pkg::Z_W-1]) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_val;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + IW'(1);
            if (r_iter == IW'(ITERS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= fold ? -x_init : x_init;
            r_y <= '0;
            r_z <= $signed({z_word[31], z_word});
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_x        = r_x;
    assign o_y        = r_y;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("CORDIC started while busy.");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("CORDIC done without a preceding iteration.");

endmodule
